/* src/ffsa_pkg.sv */
// Shared types, codes and constants of the first-fit span allocator.
package ffsa_pkg;

	localparam int MAX_BLOCKS_DEF = 8;
	localparam int MAX_SPANS_DEF  = 16;
	localparam int SIZE_BITS_DEF  = 32;

	localparam int ALIGN_W   = 17;
	localparam int MINBLK_W  = 32;
	localparam int REQ_W     = 32;
	localparam int ID_W      = 16;
	localparam int TOTAL_W   = 40;
	localparam int RND_W     = 33;
	localparam int CFG_W     = 32;
	localparam int IN_DATA_W  = 88;
	localparam int OUT_DATA_W = 160;

	localparam logic [ALIGN_W-1:0]  ALIGN_RST  = 17'd256;
	localparam logic [MINBLK_W-1:0] MINBLK_RST = 32'd33554432;

	typedef enum logic [0:0] {
		CFG_ALIGNMENT = 1'b0,
		CFG_MIN_BLOCK = 1'b1
	} cfg_idx_t;

	typedef enum logic [0:0] {
		ACT_ALLOC = 1'b0,
		ACT_FREE  = 1'b1
	} action_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_BLOCK_FULL  = 3'd1,
		ST_SPAN_FULL   = 3'd2,
		ST_UNKNOWN     = 3'd3,
		ST_SIZE_OVF    = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIV,
		S_ACHK,
		S_ASCAN_RD,
		S_ASCAN_CMP,
		S_AUPD,
		S_AOPEN,
		S_ERASE_RD,
		S_ERASE_WR,
		S_FFIND,
		S_FREE_RD,
		S_FREE_CMP,
		S_FUPD,
		S_DONE
	} fsm_t;

endpackage

/* src/ffsa_div.sv */
// Bit-serial remainder unit for rounding request sizes to the alignment.
module ffsa_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ffsa_pkg::REQ_W-1:0]    dividend,
	input  logic [ffsa_pkg::ALIGN_W-1:0]  divisor,
	output logic                          done,
	output logic [ffsa_pkg::ALIGN_W-1:0]  rem
);

	localparam int STEP_W = $clog2(ffsa_pkg::REQ_W + 1);

	logic [ffsa_pkg::REQ_W-1:0]   num_q;
	logic [ffsa_pkg::ALIGN_W-1:0] den_q;
	logic [ffsa_pkg::ALIGN_W-1:0] rem_q;
	logic [STEP_W-1:0]            step_q;
	logic                         busy_q;
	logic                         done_q;
	logic [ffsa_pkg::ALIGN_W:0]   trial;

	assign trial = {rem_q, num_q[ffsa_pkg::REQ_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(ffsa_pkg::REQ_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[ffsa_pkg::REQ_W-2:0], 1'b0};
			if (trial >= {1'b0, den_q})
				rem_q <= ffsa_pkg::ALIGN_W'(trial - {1'b0, den_q});
			else
				rem_q <= ffsa_pkg::ALIGN_W'(trial);
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

/* src/ffsa_span_mem.sv */
// Span table memory: start and length per entry, one write and one registered read port.
module ffsa_span_mem #(
	parameter int DEPTH  = 128,
	parameter int DATA_W = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DATA_W-1:0]        wstart,
	input  logic [DATA_W-1:0]        wlen,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DATA_W-1:0]        rstart,
	output logic [DATA_W-1:0]        rlen
);

	logic [DATA_W-1:0] start_mem [DEPTH];
	logic [DATA_W-1:0] len_mem   [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			start_mem[waddr] <= wstart;
			len_mem[waddr]   <= wlen;
		end
		rstart <= start_mem[raddr];
		rlen   <= len_mem[raddr];
	end

endmodule

/* src/first_fit_span_allocator.sv */
// First-fit span allocator: one item at a time, one result per item.
// Allocate: round the size (one remainder bit a cycle, then a range check), compare each
// span entry of each block in rank order if shared, open a block if nothing fits or update
// the span, then on erase move later entries down. Free: search blocks by rank, release a
// dedicated block or compare each span entry and update; erase as above. Each item ends
// in result and idle states. Reset clears valid flags, span counts, counters, sum at once.
module first_fit_span_allocator #(
	parameter int MAX_BLOCKS = ffsa_pkg::MAX_BLOCKS_DEF,
	parameter int MAX_SPANS  = ffsa_pkg::MAX_SPANS_DEF,
	parameter int SIZE_BITS  = ffsa_pkg::SIZE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// action, size_bytes, want_dedicated, free_block_id, free_offset
	input  logic [ffsa_pkg::IN_DATA_W-1:0]   s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// status, block_id, offset, reserved_size, opened_block, opened_block_size,
	// released_block, total_reserved
	output logic [ffsa_pkg::OUT_DATA_W-1:0]  m_tdata,
	input  logic                             cfg_we,
	input  logic [0:0]                       cfg_index,
	input  logic [ffsa_pkg::CFG_W-1:0]       cfg_data
);

	localparam int SLOT_W = $clog2(MAX_BLOCKS);
	localparam int RANK_W = $clog2(MAX_BLOCKS + 1);
	localparam int CNT_W  = $clog2(MAX_SPANS + 1);
	localparam int DEPTH  = MAX_BLOCKS * MAX_SPANS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam logic [63:0] SIZE_MASK = (64'd1 << SIZE_BITS) - 64'd1;

	ffsa_pkg::fsm_t state_q, state_d;

	logic [ffsa_pkg::ALIGN_W-1:0]  align_q;
	logic [ffsa_pkg::MINBLK_W-1:0] minblk_q;

	logic                        ded_q;
	logic [ffsa_pkg::REQ_W-1:0]  size_q, foff_q;
	logic [ffsa_pkg::ID_W-1:0]   fid_q;
	logic [ffsa_pkg::RND_W-1:0]  rnd_q;
	logic [ffsa_pkg::RND_W-1:0]  end_q;

	logic                        blk_valid_q [MAX_BLOCKS];
	logic [ffsa_pkg::ID_W-1:0]   blk_id_q    [MAX_BLOCKS];
	logic                        blk_ded_q   [MAX_BLOCKS];
	logic [SLOT_W-1:0]           order_q     [MAX_BLOCKS];
	logic [CNT_W-1:0]            span_cnt_q  [MAX_BLOCKS];
	logic [RANK_W-1:0]           blk_cnt_q;
	logic [ffsa_pkg::ID_W-1:0]   next_id_q;
	logic [ffsa_pkg::TOTAL_W-1:0] total_q;

	logic [RANK_W-1:0]           rank_q;
	logic [CNT_W-1:0]            k_q;
	logic [SLOT_W-1:0]           slot_q;
	logic [CNT_W-1:0]            sk_q;
	logic [SIZE_BITS-1:0]        st_q, ln_q;
	logic                        hb_q, hf_q;
	logic [CNT_W-1:0]            bk_q, fk_q;
	logic [SIZE_BITS-1:0]        bs_q, bl_q, fl_q;

	ffsa_pkg::status_t           r_status_q;
	logic [ffsa_pkg::ID_W-1:0]   r_bid_q;
	logic [31:0]                 r_off_q, r_rsz_q, r_osz_q;
	logic                        r_opened_q, r_released_q;
	logic                        m_valid_q;
	logic [ffsa_pkg::OUT_DATA_W-1:0] m_data_q;

	logic                        in_acc;
	logic                        out_free;
	logic                        div_start, div_done;
	logic [ffsa_pkg::ALIGN_W-1:0] div_den, div_rem;

	logic                        mem_we;
	logic [ADDR_W-1:0]           mem_waddr, mem_raddr;
	logic [SIZE_BITS-1:0]        mem_wstart, mem_wlen, rd_start, rd_len;

	logic [SLOT_W-1:0]           cur_slot;
	logic [CNT_W-1:0]            cur_cnt, slot_cnt;
	logic [SLOT_W-1:0]           free_slot;
	logic [SIZE_BITS-1:0]        rnd_s, size_s, mb_s, bsz_s;
	logic                        rnd_ovf, end_ovf, fit, hb_now, hf_now;
	logic [ffsa_pkg::RND_W-1:0]  rnd_calc;

	function automatic logic [ADDR_W-1:0] span_addr(logic [SLOT_W-1:0] s,
			logic [CNT_W-1:0] k);
		return ADDR_W'(ADDR_W'(s) * ADDR_W'(MAX_SPANS) + ADDR_W'(k));
	endfunction

	assign in_acc   = s_tvalid && s_tready;
	assign s_tready = (state_q == ffsa_pkg::S_IDLE);
	assign out_free = !m_valid_q || m_tready;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	assign div_den   = (align_q == '0) ? ffsa_pkg::ALIGN_W'(1) : align_q;
	assign div_start = in_acc && (s_tdata[0] == ffsa_pkg::ACT_ALLOC);

	ffsa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (s_tdata[32:1]),
		.divisor  (div_den),
		.done     (div_done),
		.rem      (div_rem)
	);

	ffsa_span_mem #(.DEPTH(DEPTH), .DATA_W(SIZE_BITS)) u_mem (
		.clk    (clk),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wstart (mem_wstart),
		.wlen   (mem_wlen),
		.raddr  (mem_raddr),
		.rstart (rd_start),
		.rlen   (rd_len)
	);

	assign rnd_calc = (div_rem == '0) ? {1'b0, size_q}
		: ffsa_pkg::RND_W'({1'b0, size_q} + ffsa_pkg::RND_W'(div_den)
			- ffsa_pkg::RND_W'(div_rem));
	assign rnd_ovf  = {31'd0, rnd_q} > SIZE_MASK;
	assign end_ovf  = {31'd0, end_q} > SIZE_MASK;
	assign rnd_s    = SIZE_BITS'(rnd_q);
	assign size_s   = SIZE_BITS'(size_q);
	assign mb_s     = ({32'd0, minblk_q} > SIZE_MASK) ? SIZE_BITS'(SIZE_MASK)
		: SIZE_BITS'(minblk_q);
	assign bsz_s    = ded_q ? rnd_s : ((rnd_s > mb_s) ? rnd_s : mb_s);

	assign cur_slot = order_q[rank_q[SLOT_W-1:0]];
	assign cur_cnt  = span_cnt_q[cur_slot];
	assign slot_cnt = span_cnt_q[slot_q];
	assign fit      = rd_len >= rnd_s;
	assign hb_now   = ({1'b0, rd_start} + {1'b0, rd_len}) == (SIZE_BITS + 1)'(foff_q);
	assign hf_now   = rd_start == SIZE_BITS'(end_q);

	always_comb begin
		free_slot = SLOT_W'(MAX_BLOCKS - 1);
		for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
			if (!blk_valid_q[i])
				free_slot = SLOT_W'(i);
		end
	end

	always_comb begin
		state_d    = state_q;
		mem_we     = 1'b0;
		mem_waddr  = span_addr(slot_q, sk_q);
		mem_wstart = '0;
		mem_wlen   = '0;
		mem_raddr  = span_addr(cur_slot, k_q);
		case (state_q)
			ffsa_pkg::S_IDLE: begin
				if (in_acc)
					state_d = (s_tdata[0] == ffsa_pkg::ACT_ALLOC) ? ffsa_pkg::S_DIV
						: ffsa_pkg::S_FFIND;
			end
			ffsa_pkg::S_DIV: begin
				if (div_done)
					state_d = ffsa_pkg::S_ACHK;
			end
			ffsa_pkg::S_ACHK: begin
				if (rnd_ovf)
					state_d = ffsa_pkg::S_DONE;
				else if (ded_q)
					state_d = ffsa_pkg::S_AOPEN;
				else
					state_d = ffsa_pkg::S_ASCAN_RD;
			end
			ffsa_pkg::S_ASCAN_RD: begin
				if (rank_q == blk_cnt_q)
					state_d = ffsa_pkg::S_AOPEN;
				else if (k_q != cur_cnt)
					state_d = ffsa_pkg::S_ASCAN_CMP;
			end
			ffsa_pkg::S_ASCAN_CMP: begin
				state_d = fit ? ffsa_pkg::S_AUPD : ffsa_pkg::S_ASCAN_RD;
			end
			ffsa_pkg::S_AUPD: begin
				mem_we     = 1'b1;
				mem_wstart = st_q + rnd_s;
				mem_wlen   = ln_q - rnd_s;
				state_d    = (ln_q == rnd_s) ? ffsa_pkg::S_ERASE_RD : ffsa_pkg::S_DONE;
			end
			ffsa_pkg::S_AOPEN: begin
				mem_waddr  = span_addr(free_slot, '0);
				mem_wstart = rnd_s;
				mem_wlen   = bsz_s - rnd_s;
				mem_we     = (blk_cnt_q < RANK_W'(MAX_BLOCKS));
				state_d    = ffsa_pkg::S_DONE;
			end
			ffsa_pkg::S_ERASE_RD: begin
				mem_raddr = span_addr(slot_q, CNT_W'(sk_q + 1'b1));
				if ((CNT_W + 1)'(sk_q) + 1'b1 < (CNT_W + 1)'(slot_cnt))
					state_d = ffsa_pkg::S_ERASE_WR;
				else
					state_d = ffsa_pkg::S_DONE;
			end
			ffsa_pkg::S_ERASE_WR: begin
				mem_we     = 1'b1;
				mem_wstart = rd_start;
				mem_wlen   = rd_len;
				state_d    = ffsa_pkg::S_ERASE_RD;
			end
			ffsa_pkg::S_FFIND: begin
				if (rank_q == blk_cnt_q)
					state_d = ffsa_pkg::S_DONE;
				else if (blk_id_q[cur_slot] == fid_q) begin
					if (blk_ded_q[cur_slot] || end_ovf || size_q == '0)
						state_d = ffsa_pkg::S_DONE;
					else
						state_d = ffsa_pkg::S_FREE_RD;
				end
			end
			ffsa_pkg::S_FREE_RD: begin
				mem_raddr = span_addr(slot_q, k_q);
				state_d   = (k_q == slot_cnt) ? ffsa_pkg::S_FUPD : ffsa_pkg::S_FREE_CMP;
			end
			ffsa_pkg::S_FREE_CMP: begin
				state_d = ffsa_pkg::S_FREE_RD;
			end
			ffsa_pkg::S_FUPD: begin
				state_d = ffsa_pkg::S_DONE;
				if (hb_q && hf_q) begin
					mem_we     = 1'b1;
					mem_waddr  = span_addr(slot_q, bk_q);
					mem_wstart = bs_q;
					mem_wlen   = bl_q + size_s + fl_q;
					state_d    = ffsa_pkg::S_ERASE_RD;
				end else if (hb_q) begin
					mem_we     = 1'b1;
					mem_waddr  = span_addr(slot_q, bk_q);
					mem_wstart = bs_q;
					mem_wlen   = bl_q + size_s;
				end else if (hf_q) begin
					mem_we     = 1'b1;
					mem_waddr  = span_addr(slot_q, fk_q);
					mem_wstart = SIZE_BITS'(foff_q);
					mem_wlen   = size_s + fl_q;
				end else if (slot_cnt < CNT_W'(MAX_SPANS)) begin
					mem_we     = 1'b1;
					mem_waddr  = span_addr(slot_q, slot_cnt);
					mem_wstart = SIZE_BITS'(foff_q);
					mem_wlen   = size_s;
				end
			end
			ffsa_pkg::S_DONE: begin
				if (out_free)
					state_d = ffsa_pkg::S_IDLE;
			end
			default: state_d = ffsa_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ffsa_pkg::S_IDLE;
			m_valid_q <= 1'b0;
			align_q   <= ffsa_pkg::ALIGN_RST;
			minblk_q  <= ffsa_pkg::MINBLK_RST;
			blk_cnt_q <= '0;
			next_id_q <= '0;
			total_q   <= '0;
			for (int i = 0; i < MAX_BLOCKS; i++) begin
				blk_valid_q[i] <= 1'b0;
				span_cnt_q[i]  <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					ffsa_pkg::CFG_ALIGNMENT: align_q  <= cfg_data[ffsa_pkg::ALIGN_W-1:0];
					ffsa_pkg::CFG_MIN_BLOCK: minblk_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == ffsa_pkg::S_DONE && out_free)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;
			case (state_q)
				ffsa_pkg::S_AUPD: begin
					total_q <= total_q + ffsa_pkg::TOTAL_W'(rnd_q);
				end
				ffsa_pkg::S_AOPEN: begin
					if (blk_cnt_q < RANK_W'(MAX_BLOCKS)) begin
						blk_valid_q[free_slot]             <= 1'b1;
						span_cnt_q[free_slot]              <= (bsz_s == rnd_s) ? '0 : CNT_W'(1);
						order_q[blk_cnt_q[SLOT_W-1:0]]     <= free_slot;
						blk_cnt_q                          <= blk_cnt_q + 1'b1;
						next_id_q                          <= next_id_q + 1'b1;
						total_q <= total_q + ffsa_pkg::TOTAL_W'(rnd_q);
					end
				end
				ffsa_pkg::S_ERASE_RD: begin
					if (!((CNT_W + 1)'(sk_q) + 1'b1 < (CNT_W + 1)'(slot_cnt)))
						span_cnt_q[slot_q] <= slot_cnt - 1'b1;
				end
				ffsa_pkg::S_FFIND: begin
					if (rank_q != blk_cnt_q && blk_id_q[cur_slot] == fid_q) begin
						if (blk_ded_q[cur_slot]) begin
							blk_valid_q[cur_slot] <= 1'b0;
							for (int i = 0; i < MAX_BLOCKS - 1; i++) begin
								if (RANK_W'(i) >= rank_q)
									order_q[i] <= order_q[i+1];
							end
							blk_cnt_q <= blk_cnt_q - 1'b1;
							total_q   <= total_q - ffsa_pkg::TOTAL_W'(size_q);
						end else if (!end_ovf && size_q == '0) begin
							total_q <= total_q - ffsa_pkg::TOTAL_W'(size_q);
						end
					end
				end
				ffsa_pkg::S_FUPD: begin
					if (hb_q || hf_q || slot_cnt < CNT_W'(MAX_SPANS))
						total_q <= total_q - ffsa_pkg::TOTAL_W'(size_q);
					if (!hb_q && !hf_q && slot_cnt < CNT_W'(MAX_SPANS))
						span_cnt_q[slot_q] <= slot_cnt + 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ffsa_pkg::S_IDLE: begin
				if (in_acc) begin
					size_q       <= s_tdata[32:1];
					ded_q        <= s_tdata[33];
					fid_q        <= s_tdata[49:34];
					foff_q       <= s_tdata[81:50];
					end_q        <= {1'b0, s_tdata[81:50]} + {1'b0, s_tdata[32:1]};
					rank_q       <= '0;
					k_q          <= '0;
					r_status_q   <= ffsa_pkg::ST_OK;
					r_bid_q      <= '0;
					r_off_q      <= '0;
					r_rsz_q      <= '0;
					r_opened_q   <= 1'b0;
					r_osz_q      <= '0;
					r_released_q <= 1'b0;
				end
			end
			ffsa_pkg::S_DIV: begin
				if (div_done)
					rnd_q <= rnd_calc;
			end
			ffsa_pkg::S_ACHK: begin
				if (rnd_ovf)
					r_status_q <= ffsa_pkg::ST_SIZE_OVF;
			end
			ffsa_pkg::S_ASCAN_RD: begin
				if (rank_q != blk_cnt_q && k_q == cur_cnt) begin
					rank_q <= rank_q + 1'b1;
					k_q    <= '0;
				end
			end
			ffsa_pkg::S_ASCAN_CMP: begin
				if (fit) begin
					slot_q <= cur_slot;
					sk_q   <= k_q;
					st_q   <= rd_start;
					ln_q   <= rd_len;
				end else begin
					k_q <= k_q + 1'b1;
				end
			end
			ffsa_pkg::S_AUPD: begin
				r_bid_q <= blk_id_q[slot_q];
				r_off_q <= 32'(st_q);
				r_rsz_q <= 32'(rnd_q);
			end
			ffsa_pkg::S_AOPEN: begin
				if (blk_cnt_q < RANK_W'(MAX_BLOCKS)) begin
					blk_id_q[free_slot]  <= next_id_q;
					blk_ded_q[free_slot] <= ded_q;
					r_bid_q    <= next_id_q;
					r_rsz_q    <= 32'(rnd_q);
					r_opened_q <= 1'b1;
					r_osz_q    <= 32'(bsz_s);
				end else begin
					r_status_q <= ffsa_pkg::ST_BLOCK_FULL;
				end
			end
			ffsa_pkg::S_ERASE_WR: begin
				sk_q <= sk_q + 1'b1;
			end
			ffsa_pkg::S_FFIND: begin
				if (rank_q == blk_cnt_q) begin
					r_status_q <= ffsa_pkg::ST_UNKNOWN;
				end else if (blk_id_q[cur_slot] == fid_q) begin
					slot_q <= cur_slot;
					k_q    <= '0;
					hb_q   <= 1'b0;
					hf_q   <= 1'b0;
					if (blk_ded_q[cur_slot])
						r_released_q <= 1'b1;
					else if (end_ovf)
						r_status_q <= ffsa_pkg::ST_SIZE_OVF;
				end else begin
					rank_q <= rank_q + 1'b1;
				end
			end
			ffsa_pkg::S_FREE_CMP: begin
				k_q <= k_q + 1'b1;
				if (!hb_q && hb_now) begin
					hb_q <= 1'b1;
					bk_q <= k_q;
					bs_q <= rd_start;
					bl_q <= rd_len;
				end
				if (!hf_q && hf_now) begin
					hf_q <= 1'b1;
					fk_q <= k_q;
					fl_q <= rd_len;
				end
			end
			ffsa_pkg::S_FUPD: begin
				sk_q <= fk_q;
				if (!hb_q && !hf_q && slot_cnt >= CNT_W'(MAX_SPANS))
					r_status_q <= ffsa_pkg::ST_SPAN_FULL;
			end
			ffsa_pkg::S_DONE: begin
				if (out_free) begin
					m_data_q <= {3'd0, total_q, r_released_q, r_osz_q, r_opened_q,
						r_rsz_q, r_off_q, r_bid_q, r_status_q};
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	logic [RANK_W-1:0] valid_ones;
	always_comb begin
		valid_ones = '0;
		for (int i = 0; i < MAX_BLOCKS; i++)
			valid_ones = valid_ones + RANK_W'(blk_valid_q[i]);
	end

	a_blk_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		blk_cnt_q <= RANK_W'(MAX_BLOCKS))
		else $error("block count beyond table size");

	a_valid_matches_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		valid_ones == blk_cnt_q)
		else $error("valid blocks disagree with block count");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q != ffsa_pkg::S_IDLE && state_q != ffsa_pkg::S_DONE))
		else $error("span write outside item processing");

	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && m_tready && state_q != ffsa_pkg::S_DONE) |=> !m_valid_q)
		else $error("result repeated");
`endif

endmodule

/* sim/tb_top.sv */
// Testbench for first_fit_span_allocator: queued random and directed items, predicted results.
module tb_top;

	localparam int NB = ffsa_pkg::MAX_BLOCKS_DEF;
	localparam int NS = ffsa_pkg::MAX_SPANS_DEF;
	localparam longint LIMIT = 5000000;

	typedef struct {
		ffsa_pkg::status_t st;
		logic [15:0] bid;
		logic [31:0] off;
		logic [31:0] rsz;
		logic        op;
		logic [31:0] osz;
		logic        rel;
		logic [39:0] tot;
	} alloc_res_t;

	typedef struct {
		logic [15:0] id;
		logic [31:0] off;
		logic [31:0] sz;
	} grant_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [ffsa_pkg::IN_DATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [ffsa_pkg::OUT_DATA_W-1:0] m_tdata;
	logic cfg_we = 0;
	logic [0:0] cfg_index = ffsa_pkg::CFG_ALIGNMENT;
	logic [ffsa_pkg::CFG_W-1:0] cfg_data = '0;

	first_fit_span_allocator DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// allocator state as predicted
	logic [63:0] cur_align, cur_minblk;
	bit          blk_live[NB];
	logic [15:0] blk_tag[NB];
	bit          blk_ded[NB];
	int          rank_slot[NB];
	int          nblk;
	logic [63:0] sp_base[NB][NS];
	logic [63:0] sp_len[NB][NS];
	int          nsp[NB];
	logic [15:0] tag_ctr;
	logic [39:0] run_sum;

	logic [ffsa_pkg::IN_DATA_W-1:0] pending_q[$];
	alloc_res_t           result_q[$];
	grant_t               grants[$];
	int  fails = 0;
	int  snd_idle = 0, rcv_idle = 0;
	int  n_ok = 0, n_err = 0, n_free = 0;
	bit  in_acc = 0;
	longint cycles = 0;

	function automatic void span_drop(int s, int k);
		for (int i = k; i + 1 < nsp[s]; i++) begin
			sp_base[s][i] = sp_base[s][i+1];
			sp_len[s][i] = sp_len[s][i+1];
		end
		nsp[s]--;
	endfunction

	function automatic alloc_res_t alloc_or_free(logic act, logic [31:0] sz, logic ded,
			logic [15:0] id, logic [31:0] foff);
		alloc_res_t r;
		logic [63:0] a, rounded, bsz, size, endp;
		int slot, sk, s, rank, bk, fk;
		bit found, hit, hb, hf;
		r.st = ffsa_pkg::ST_OK; r.bid = 0; r.off = 0; r.rsz = 0; r.op = 0; r.osz = 0;
		r.rel = 0;
		size = sz;
		found = 0; hit = 0; slot = 0; sk = 0; rank = 0;
		if (act == ffsa_pkg::ACT_ALLOC) begin
			a = (cur_align == 0) ? 64'd1 : cur_align;
			rounded = ((size + a - 1) / a) * a;
			if (rounded > 64'hFFFF_FFFF) begin
				r.st = ffsa_pkg::ST_SIZE_OVF;
			end else begin
				if (!ded)
					for (int q = 0; q < nblk && !found; q++) begin
						s = rank_slot[q];
						for (int k = 0; k < nsp[s] && !found; k++)
							if (sp_len[s][k] >= rounded) begin
								slot = s; sk = k; found = 1;
							end
					end
				if (!found) begin
					bsz = ded ? rounded : (rounded > cur_minblk ? rounded : cur_minblk);
					if (nblk >= NB) begin
						r.st = ffsa_pkg::ST_BLOCK_FULL;
					end else begin
						slot = 0;
						while (slot + 1 < NB && blk_live[slot]) slot++;
						blk_live[slot] = 1;
						blk_tag[slot] = tag_ctr;
						tag_ctr++;
						blk_ded[slot] = ded;
						sp_base[slot][0] = 0;
						sp_len[slot][0] = bsz;
						nsp[slot] = 1;
						rank_slot[nblk] = slot;
						nblk++;
						sk = 0;
						r.op = 1;
						r.osz = bsz[31:0];
					end
				end
				if (r.st == ffsa_pkg::ST_OK) begin
					r.bid = blk_tag[slot];
					r.off = sp_base[slot][sk][31:0];
					r.rsz = rounded[31:0];
					sp_base[slot][sk] += rounded;
					sp_len[slot][sk] -= rounded;
					if (sp_len[slot][sk] == 0) span_drop(slot, sk);
					run_sum += rounded[39:0];
				end
			end
		end else begin
			for (int q = 0; q < nblk && !hit; q++)
				if (blk_tag[rank_slot[q]] == id) begin
					rank = q; hit = 1;
				end
			if (!hit) begin
				r.st = ffsa_pkg::ST_UNKNOWN;
			end else begin
				s = rank_slot[rank];
				endp = {32'd0, foff} + size;
				if (blk_ded[s]) begin
					blk_live[s] = 0;
					for (int i = rank; i + 1 < nblk; i++) rank_slot[i] = rank_slot[i+1];
					nblk--;
					r.rel = 1;
				end else if (endp > 64'hFFFF_FFFF) begin
					r.st = ffsa_pkg::ST_SIZE_OVF;
				end else if (size != 0) begin
					hb = 0; hf = 0; bk = 0; fk = 0;
					for (int i = 0; i < nsp[s]; i++) begin
						if (!hb && sp_base[s][i] + sp_len[s][i] == foff) begin
							hb = 1; bk = i;
						end
						if (!hf && sp_base[s][i] == endp) begin
							hf = 1; fk = i;
						end
					end
					if (hb && hf) begin
						sp_len[s][bk] += size + sp_len[s][fk];
						span_drop(s, fk);
					end else if (hb) begin
						sp_len[s][bk] += size;
					end else if (hf) begin
						sp_base[s][fk] = foff;
						sp_len[s][fk] += size;
					end else if (nsp[s] >= NS) begin
						r.st = ffsa_pkg::ST_SPAN_FULL;
					end else begin
						sp_base[s][nsp[s]] = foff;
						sp_len[s][nsp[s]] = size;
						nsp[s]++;
					end
				end
				if (r.st == ffsa_pkg::ST_OK) run_sum -= size[39:0];
			end
		end
		r.tot = run_sum;
		return r;
	endfunction

	task automatic push_item(logic act, logic [31:0] sz, logic ded, logic [15:0] id,
			logic [31:0] foff, output alloc_res_t r);
		r = alloc_or_free(act, sz, ded, id, foff);
		pending_q.insert(pending_q.size(), {6'd0, foff, id, ded, sz, act});
		result_q.insert(result_q.size(), r);
	endtask

	task automatic do_alloc(logic [31:0] sz, logic ded);
		alloc_res_t r;
		grant_t g;
		push_item(ffsa_pkg::ACT_ALLOC, sz, ded, 16'd0, 32'd0, r);
		if (r.st == ffsa_pkg::ST_OK) begin
			g.id = r.bid; g.off = r.off; g.sz = r.rsz;
			grants.insert(grants.size(), g);
		end
	endtask

	task automatic do_release(int idx);
		alloc_res_t r;
		grant_t g;
		g = grants[idx];
		push_item(ffsa_pkg::ACT_FREE, g.sz, 1'($urandom_range(0, 1)), g.id, g.off, r);
		if (r.st == ffsa_pkg::ST_OK) grants.delete(idx);
	endtask

	task automatic do_raw_free(logic [31:0] sz, logic [15:0] id, logic [31:0] foff);
		alloc_res_t r;
		push_item(ffsa_pkg::ACT_FREE, sz, 1'($urandom_range(0, 1)), id, foff, r);
	endtask

	task automatic drain_and_set(logic [31:0] align, logic [31:0] minblk);
		while (pending_q.size() != 0 || result_q.size() != 0) @(posedge clk);
		repeat (4) @(negedge clk);
		cfg_we <= 1; cfg_index <= ffsa_pkg::CFG_ALIGNMENT; cfg_data <= align;
		@(negedge clk);
		cfg_index <= ffsa_pkg::CFG_MIN_BLOCK; cfg_data <= minblk;
		@(negedge clk);
		cfg_we <= 0;
		cur_align = align[16:0];
		cur_minblk = minblk;
	endtask

	function automatic logic [31:0] rand_size();
		int p;
		p = $urandom_range(0, 99);
		if (p < 70) return 32'($urandom_range(0, 4096));
		if (p < 90) return 32'($urandom_range(0, 1 << 20));
		if (p < 98) return 32'($urandom_range(0, 1 << 28));
		return $urandom;
	endfunction

	// driver
	always @(posedge clk) in_acc <= s_tvalid && s_tready;

	always @(negedge clk) begin
		if (!s_tvalid || in_acc) begin
			if (pending_q.size() != 0 && $urandom_range(0, 99) >= snd_idle) begin
				s_tdata <= pending_q.pop_front();
				s_tvalid <= 1;
			end else begin
				s_tvalid <= 0;
			end
		end
		m_tready <= ($urandom_range(0, 99) >= rcv_idle);
	end

	// monitor
	always @(posedge clk) begin
		alloc_res_t e;
		cycles++;
		if (cycles > LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
		if (m_tvalid && m_tready) begin
			if (result_q.size() == 0) begin
				$error("result with nothing expected");
				fails++;
			end else begin
				e = result_q.pop_front();
				if (e.st == ffsa_pkg::ST_OK) n_ok++; else n_err++;
				if (m_tdata[2:0] !== e.st) begin
					$error("status exp %0d got %0d", e.st, m_tdata[2:0]); fails++;
				end
				if (m_tdata[18:3] !== e.bid) begin
					$error("block_id exp %0h got %0h", e.bid, m_tdata[18:3]); fails++;
				end
				if (m_tdata[50:19] !== e.off) begin
					$error("offset exp %0h got %0h", e.off, m_tdata[50:19]); fails++;
				end
				if (m_tdata[82:51] !== e.rsz) begin
					$error("reserved_size exp %0h got %0h", e.rsz, m_tdata[82:51]); fails++;
				end
				if (m_tdata[83] !== e.op) begin
					$error("opened_block exp %0b got %0b", e.op, m_tdata[83]); fails++;
				end
				if (m_tdata[115:84] !== e.osz) begin
					$error("opened_block_size exp %0h got %0h", e.osz, m_tdata[115:84]);
					fails++;
				end
				if (m_tdata[116] !== e.rel) begin
					$error("released_block exp %0b got %0b", e.rel, m_tdata[116]); fails++;
				end
				if (m_tdata[156:117] !== e.tot) begin
					$error("total_reserved exp %0h got %0h", e.tot, m_tdata[156:117]);
					fails++;
				end
			end
		end
	end

	initial begin
		int p, n;
		logic [31:0] gid_off;
		cur_align = ffsa_pkg::ALIGN_RST;
		cur_minblk = ffsa_pkg::MINBLK_RST;
		for (int i = 0; i < NB; i++) begin
			blk_live[i] = 0; nsp[i] = 0; rank_slot[i] = 0;
		end
		nblk = 0; tag_ctr = 0; run_sum = 0;
		repeat (2) @(negedge clk);
		arst_n = 1;
		snd_idle = 24; rcv_idle = 82;
		drain_and_set(32'd256, 32'd33554432);

		// directed: extremes, dedicated release, unknown block, merges, limits
		do_alloc(32'd0, 0);
		do_alloc(32'd1, 0);
		do_alloc(32'hFFFF_FFFF, 0);
		do_alloc(32'd5000, 1);
		do_release(grants.size() - 1);
		do_raw_free(32'd256, 16'hFFFF, 32'd0);
		do_raw_free(32'h100, grants[0].id, 32'hFFFF_FFF0);
		do_raw_free(32'd0, grants[0].id, 32'h1234_5678);
		do_alloc(32'd300, 0);
		do_alloc(32'd300, 0);
		do_alloc(32'd300, 0);
		n = grants.size();
		do_release(n - 3);
		do_release(n - 2);
		do_release(n - 3);
		for (int i = 0; i < 8; i++) do_alloc(32'd1000, 1);
		for (int i = grants.size() - 1; i >= 1; i--) do_release(i);
		for (int i = 0; i < 34; i++) do_alloc(32'd256, 0);
		n = grants.size();
		for (int i = n - 33; i < n; i += 2) do_raw_free(grants[i].sz, grants[i].id, grants[i].off);
		for (int i = grants.size() - 1; i >= 0; i--) do_release(i);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					snd_idle = 24; rcv_idle = 82;
					drain_and_set(32'd1, 32'd0);
				end
				1: begin
					snd_idle = 82; rcv_idle = 24;
					drain_and_set(32'd65536, 32'hFFFF_FFFF);
				end
				2: begin
					snd_idle = 0; rcv_idle = 0;
					drain_and_set(32'd512, 32'd8192);
				end
				default: begin
					drain_and_set(32'd256, 32'd33554432);
				end
			endcase
			for (int i = 0; i < 500; i++) begin
				p = $urandom_range(0, 99);
				if (p < 45 && grants.size() != 0) begin
					do_release($urandom_range(0, grants.size() - 1));
				end else if (p < 52) begin
					gid_off = $urandom;
					if (grants.size() != 0 && p < 49)
						do_raw_free(rand_size(), grants[0].id, gid_off);
					else
						do_raw_free($urandom, 16'($urandom), gid_off);
				end else begin
					do_alloc(rand_size(), $urandom_range(0, 9) == 0);
				end
			end
		end

		while (pending_q.size() != 0 || result_q.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		$display("Covered %0d ok and %0d flagged results over four register settings,",
			n_ok, n_err);
		$display("with sender and receiver stalls in both directions and none.");
		if (fails == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

/* filelist.f */
src/ffsa_pkg.sv
src/ffsa_div.sv
src/ffsa_span_mem.sv
src/first_fit_span_allocator.sv
sim/tb_top.sv
